// File: sv/ffha_pkg.sv
package ffha_pkg;

  localparam int unsigned HeapBytes = 65536;
  localparam int unsigned Granules  = HeapBytes / 8;
  localparam int unsigned GranAw    = $clog2(Granules);
  localparam int unsigned PosW      = GranAw + 1;
  localparam int unsigned SizeW     = $clog2(HeapBytes);
  localparam int unsigned HdrW      = SizeW + 1;
  localparam int unsigned NW        = (SizeW > 18) ? SizeW : 18;
  localparam int unsigned CmpW      = NW + 1;

  localparam logic [SizeW-1:0] InitSize = SizeW'(HeapBytes - 8);

  typedef enum logic [1:0] {
    ReqAlloc  = 2'd0,
    ReqFree   = 2'd1,
    ReqResize = 2'd2,
    ReqNone   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StNoFit = 2'd1,
    StZero  = 2'd2
  } status_e;

  typedef struct packed {
    logic             rsv;
    logic [SizeW-1:0] size;
  } hdr_t;

  typedef enum logic [12:0] {
    SIdle  = 13'b0000000000001,
    SFdRd  = 13'b0000000000010,
    SFdCk  = 13'b0000000000100,
    SMgCk  = 13'b0000000001000,
    SNxRd  = 13'b0000000010000,
    SNxCk  = 13'b0000000100000,
    SMgWr  = 13'b0000001000000,
    SAlRd  = 13'b0000010000000,
    SAlCk  = 13'b0000100000000,
    SSpWr1 = 13'b0001000000000,
    SSpWr2 = 13'b0010000000000,
    SDone  = 13'b0100000000000,
    SStart = 13'b1000000000000
  } state_e;

endpackage

// File: sv/ffha_ram.sv
module ffha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sv/first_fit_heap_allocator.sv
// channel   | dir | handshake               | payload
// s_axis    | in  | s_axis_tvalid/tready    | tuser: req_type; tdata: size_bytes, block_address
// m_axis    | out | m_axis_tvalid/tready    | tdata: result_address, status, moved
// apb       | in  | psel & penable & pwrite | heap_base at byte address 0
//
// steps: accept, start and done are states of their own; each header visited is read, then
// checked in lookup, merge and first-fit walks alike; a merge writes one header, a split writes
// the remainder then the reserved one; moving resizes restart via start; fragmentation sets pace
// reset: only header 0 is live after reset; a flag makes it read as one whole-heap free
// block until it is first written, so no clearing pass is needed
// stalls: a finished item waits in the output register while the next is taken and walked
module first_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [16:0] size_bytes, [48:17] block_address, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // item out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] result_address, [33:32] status, [34] moved
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned GranAw = ffha_pkg::GranAw;
  localparam int unsigned PosW   = ffha_pkg::PosW;
  localparam int unsigned SizeW  = ffha_pkg::SizeW;
  localparam int unsigned NW     = ffha_pkg::NW;
  localparam int unsigned CmpW   = ffha_pkg::CmpW;

  // configuration register
  logic [31:0] base_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & ~paddr[2];
  assign prdata = paddr[2] ? 32'd0 : base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd0;
    end else if (cfg_we) begin
      base_q <= pwdata;
    end
  end

  // control state
  ffha_pkg::state_e state_q, state_d;
  ffha_pkg::req_e   op_q, op_d;
  logic             init_q, init_d;     // header 0 written since reset
  logic             rd0_q;              // last read was at header 0
  logic             mv_q, mv_d;         // walk is a resize moving elsewhere
  logic             ovld_q, ovld_d;

  // working registers
  logic [NW-1:0]     n_q, n_d;          // rounded request
  logic [31:0]       addr_q, addr_d;    // original block address
  logic [31:0]       off_q, off_d;      // target header offset
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   nxt_q, nxt_d;
  logic [GranAw-1:0] cur_q, cur_d;
  logic [SizeW-1:0]  sz_q, sz_d;
  logic [31:0]       raddr_q, raddr_d;  // pending result
  ffha_pkg::status_e rst_q, rst_d;
  logic              rmv_q, rmv_d;
  logic [31:0]       oaddr_q, oaddr_d;
  ffha_pkg::status_e ost_q, ost_d;
  logic              omv_q, omv_d;

  // memory port
  logic              we;
  logic [GranAw-1:0] waddr, rdaddr;
  ffha_pkg::hdr_t    wdata, ram_q, hdr;
  logic              re;

  ffha_ram #(
    .Width ($bits(ffha_pkg::hdr_t)),
    .Depth (ffha_pkg::Granules)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rdaddr),
    .rdata_o (ram_q)
  );

  always_comb begin
    hdr = ram_q;
    if (rd0_q && !init_q) begin
      hdr.rsv  = 1'b0;
      hdr.size = ffha_pkg::InitSize;
    end
  end

  // input fields
  logic [16:0] in_size;
  logic [31:0] in_addr;
  logic [NW-1:0] in_n;
  assign in_size = s_axis_tdata[16:0];
  assign in_addr = s_axis_tdata[48:17];
  assign in_n    = (NW'(in_size) + NW'(7)) & ~NW'(7);

  assign s_axis_tready = (state_q == ffha_pkg::SIdle);

  // walk arithmetic
  logic [PosW-1:0] pos_step, nxt_step;
  logic            fits, fits_mg;
  assign pos_step = pos_q + PosW'(hdr.size[SizeW-1:3]) + PosW'(1);
  assign nxt_step = nxt_q + PosW'(hdr.size[SizeW-1:3]) + PosW'(1);
  assign fits     = !hdr.rsv && (CmpW'(hdr.size) > (CmpW'(n_q) + CmpW'(8)));
  assign fits_mg  = (n_q != '0) && (CmpW'(sz_q) > (CmpW'(n_q) + CmpW'(8)));

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    init_d  = init_q;
    mv_d    = mv_q;
    ovld_d  = ovld_q;
    n_d     = n_q;
    addr_d  = addr_q;
    off_d   = off_q;
    pos_d   = pos_q;
    nxt_d   = nxt_q;
    cur_d   = cur_q;
    sz_d    = sz_q;
    raddr_d = raddr_q;
    rst_d   = rst_q;
    rmv_d   = rmv_q;
    oaddr_d = oaddr_q;
    ost_d   = ost_q;
    omv_d   = omv_q;
    we      = 1'b0;
    waddr   = cur_q;
    wdata   = '{rsv: 1'b0, size: sz_q};
    re      = 1'b0;
    rdaddr  = pos_q[GranAw-1:0];

    if (m_axis_tready) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      ffha_pkg::SIdle: begin
        if (s_axis_tvalid) begin
          op_d    = ffha_pkg::req_e'(s_axis_tuser);
          n_d     = in_n;
          addr_d  = in_addr;
          off_d   = in_addr - base_q - 32'd8;
          pos_d   = '0;
          mv_d    = 1'b0;
          raddr_d = 32'd0;
          rst_d   = ffha_pkg::StOk;
          rmv_d   = 1'b0;
          state_d = ffha_pkg::SStart;
        end
      end
      ffha_pkg::SStart: begin
        unique case (op_q)
          ffha_pkg::ReqAlloc: begin
            if (n_q == '0) begin
              rst_d   = ffha_pkg::StZero;
              state_d = ffha_pkg::SDone;
            end else begin
              state_d = ffha_pkg::SAlRd;
            end
          end
          ffha_pkg::ReqFree, ffha_pkg::ReqResize: begin
            if (addr_q == 32'd0) begin
              op_d    = (op_q == ffha_pkg::ReqResize) ? ffha_pkg::ReqAlloc : ffha_pkg::ReqNone;
              state_d = (op_q == ffha_pkg::ReqResize) ? ffha_pkg::SStart : ffha_pkg::SDone;
            end else begin
              state_d = ffha_pkg::SFdRd;
            end
          end
          default: state_d = ffha_pkg::SDone;
        endcase
      end
      // address lookup walk
      ffha_pkg::SFdRd: begin
        if (pos_q[GranAw]) begin
          // unknown address: free does nothing, resize allocates
          op_d    = (op_q == ffha_pkg::ReqResize) ? ffha_pkg::ReqAlloc : ffha_pkg::ReqNone;
          pos_d   = '0;
          state_d = (op_q == ffha_pkg::ReqResize) ? ffha_pkg::SStart : ffha_pkg::SDone;
        end else if (32'({pos_q[GranAw-1:0], 3'b000}) == off_q) begin
          cur_d   = pos_q[GranAw-1:0];
          re      = 1'b1;
          state_d = ffha_pkg::SMgCk;
        end else begin
          re      = 1'b1;
          state_d = ffha_pkg::SFdCk;
        end
      end
      ffha_pkg::SFdCk: begin
        pos_d   = pos_step;
        state_d = ffha_pkg::SFdRd;
      end
      // free and merge the following free blocks
      ffha_pkg::SMgCk: begin
        sz_d    = hdr.size;
        nxt_d   = PosW'(cur_q) + PosW'(hdr.size[SizeW-1:3]) + PosW'(1);
        state_d = ffha_pkg::SNxRd;
      end
      ffha_pkg::SNxRd: begin
        if (nxt_q[GranAw]) begin
          state_d = ffha_pkg::SMgWr;
        end else begin
          re      = 1'b1;
          rdaddr  = nxt_q[GranAw-1:0];
          state_d = ffha_pkg::SNxCk;
        end
      end
      ffha_pkg::SNxCk: begin
        if (hdr.rsv) begin
          state_d = ffha_pkg::SMgWr;
        end else begin
          sz_d    = sz_q + hdr.size + SizeW'(8);
          nxt_d   = nxt_step;
          state_d = ffha_pkg::SNxRd;
        end
      end
      ffha_pkg::SMgWr: begin
        we    = 1'b1;
        waddr = cur_q;
        wdata = '{rsv: 1'b0, size: sz_q};
        if (cur_q == '0) begin
          init_d = 1'b1;
        end
        if (op_q != ffha_pkg::ReqResize) begin
          state_d = ffha_pkg::SDone;
        end else if (fits_mg) begin
          // keep in place
          raddr_d = addr_q;
          state_d = ffha_pkg::SSpWr1;
        end else begin
          op_d    = ffha_pkg::ReqAlloc;
          mv_d    = 1'b1;
          pos_d   = '0;
          state_d = ffha_pkg::SStart;
        end
      end
      // first-fit walk
      ffha_pkg::SAlRd: begin
        if (pos_q[GranAw]) begin
          rst_d   = ffha_pkg::StNoFit;
          state_d = ffha_pkg::SDone;
        end else begin
          re      = 1'b1;
          state_d = ffha_pkg::SAlCk;
        end
      end
      ffha_pkg::SAlCk: begin
        if (fits) begin
          cur_d   = pos_q[GranAw-1:0];
          sz_d    = hdr.size;
          raddr_d = base_q + 32'({pos_q[GranAw-1:0], 3'b000}) + 32'd8;
          rmv_d   = mv_q;
          state_d = ffha_pkg::SSpWr1;
        end else begin
          pos_d   = pos_step;
          state_d = ffha_pkg::SAlRd;
        end
      end
      // split: remainder header, then the reserved header
      ffha_pkg::SSpWr1: begin
        we      = 1'b1;
        waddr   = cur_q + GranAw'(n_q[SizeW-1:3]) + GranAw'(1);
        wdata   = '{rsv: 1'b0, size: sz_q - n_q[SizeW-1:0] - SizeW'(8)};
        state_d = ffha_pkg::SSpWr2;
      end
      ffha_pkg::SSpWr2: begin
        we      = 1'b1;
        waddr   = cur_q;
        wdata   = '{rsv: 1'b1, size: n_q[SizeW-1:0]};
        if (cur_q == '0) begin
          init_d = 1'b1;
        end
        state_d = ffha_pkg::SDone;
      end
      ffha_pkg::SDone: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d  = 1'b1;
          oaddr_d = raddr_q;
          ost_d   = rst_q;
          omv_d   = rmv_q;
          state_d = ffha_pkg::SIdle;
        end
      end
      default: state_d = ffha_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::SIdle;
      op_q    <= ffha_pkg::ReqNone;
      init_q  <= 1'b0;
      rd0_q   <= 1'b0;
      mv_q    <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      init_q  <= init_d;
      mv_q    <= mv_d;
      ovld_q  <= ovld_d;
      if (re) begin
        rd0_q <= (rdaddr == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    addr_q  <= addr_d;
    off_q   <= off_d;
    pos_q   <= pos_d;
    nxt_q   <= nxt_d;
    cur_q   <= cur_d;
    sz_q    <= sz_d;
    raddr_q <= raddr_d;
    rst_q   <= rst_d;
    rmv_q   <= rmv_d;
    oaddr_q <= oaddr_d;
    ost_q   <= ost_d;
    omv_q   <= omv_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {5'd0, omv_q, ost_q, oaddr_q};

endmodule
